@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// clocked check, also live during reset
`define ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/core/hrrn_pkg.sv @@
`timescale 1ns / 1ps

package hrrn_pkg;

    typedef struct packed {
        logic        action;
        logic [7:0]  proc_id;
        logic [15:0] arrive_at;
        logic [15:0] run_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  chosen_id;
        logic [20:0] finish_time;
        logic [20:0] turnaround;
        logic [20:0] wait_time;
        logic [24:0] sum_turnaround;
        logic [24:0] sum_wait;
        logic        is_last;
    } t_out_item;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] arr;
        logic [15:0] burst;
    } t_entry;

    typedef struct packed {
        t_op    op;
        t_entry ent;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GAP,
        S_GAPEND,
        S_GAPFIX,
        S_BRD,
        S_BMUL,
        S_BCMP,
        S_RUN
    } t_state;

endpackage

@@ rtl/core/hrrn_ram.sv @@
`timescale 1ns / 1ps

module hrrn_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/hrrn_front.sv @@
`timescale 1ns / 1ps

module hrrn_front import hrrn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    output logic     o_full,
    input  t_in_item i_item,
    output logic     o_cmd_valid,
    output t_cmd     o_cmd,
    input  logic     i_cmd_take
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       w_in;
    logic       w_out;
    t_cmd       w_cmd;

    // classify the incoming item
    always_comb begin
        w_cmd.op        = t_op'(i_item.action);
        w_cmd.ent.id    = i_item.proc_id;
        w_cmd.ent.arr   = i_item.arrive_at;
        w_cmd.ent.burst = i_item.run_length;
    end

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_take && o_cmd_valid;

    always_comb begin
        n_wp  = r_wp ^ w_in;
        n_rp  = r_rp ^ w_out;
        n_cnt = r_cnt + {1'b0, w_in} - {1'b0, w_out};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_slot[r_wp] <= w_cmd;
        end
    end

endmodule

@@ rtl/core/hrrn_back.sv @@
`timescale 1ns / 1ps

module hrrn_back import hrrn_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_cmd_take,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);

    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int TW = 16 + $clog2(MAX_PROCS + 2);
    localparam int SW = TW + $clog2(MAX_PROCS + 1);
    localparam int NW = TW + 1;
    localparam int PW = NW + 16;
    localparam int EW = $bits(t_entry);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_count, n_count;
    logic [CW-1:0]  r_idx, n_idx;
    logic [CW-1:0]  r_k, n_k;
    logic [MAX_PROCS-1:0] r_done, n_done;
    logic [TW-1:0]  r_time, n_time;
    logic [SW-1:0]  r_sum_tat, n_sum_tat;
    logic [SW-1:0]  r_sum_wt, n_sum_wt;
    logic           r_gv, n_gv;
    logic [CW-1:0]  r_gi, n_gi;
    logic           r_any, n_any;
    logic           r_gfound, n_gfound;
    logic [15:0]    r_gmin, n_gmin;
    logic           r_bfound, n_bfound;
    logic [CW-1:0]  r_best_idx, n_best_idx;
    t_entry         r_best, n_best;
    logic [NW-1:0]  r_best_na, n_best_na;
    logic [15:0]    r_best_b1, n_best_b1;
    logic           r_cand, n_cand;
    t_entry         r_c, n_c;
    logic [NW-1:0]  r_c_na, n_c_na;
    logic [15:0]    r_c_b1, n_c_b1;
    logic [PW-1:0]  r_pl, n_pl;
    logic [PW-1:0]  r_pr, n_pr;
    logic           r_ov, n_ov;
    t_out_item      r_out, n_out;

    logic           w_we;
    t_entry         w_rd;
    logic [EW-1:0]  w_rd_raw;
    logic [CW-1:0]  w_last;
    logic [15:0]    w_b1;
    logic [NW-1:0]  w_na;
    logic [TW-1:0]  w_fin;
    logic [TW-1:0]  w_tat;
    logic [TW-1:0]  w_wt;
    logic [SW-1:0]  w_sum_tat;
    logic [SW-1:0]  w_sum_wt;
    logic           w_out_free;
    logic           w_win;

    hrrn_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (i_cmd.ent),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rd_raw)
    );

    assign w_rd       = t_entry'(w_rd_raw);
    assign w_last     = CW'(r_count - CW'(1));
    assign w_b1       = (w_rd.burst == 16'd0) ? 16'd1 : w_rd.burst;
    assign w_na       = NW'(r_time) - NW'(w_rd.arr) + NW'(w_b1);
    assign w_fin      = r_time + TW'(r_best.burst);
    assign w_tat      = w_fin - TW'(r_best.arr);
    assign w_wt       = w_tat - TW'(r_best.burst);
    assign w_sum_tat  = r_sum_tat + SW'(w_tat);
    assign w_sum_wt   = r_sum_wt + SW'(w_wt);
    assign w_out_free = !r_ov || i_pop;
    // ties go to the earlier arrival; later table slots never win a full tie
    assign w_win      = r_cand && (!r_bfound || (r_pl > r_pr) ||
                        ((r_pl == r_pr) && (r_c.arr < r_best.arr)));

    assign o_empty = !r_ov;
    assign o_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_k        = r_k;
        n_done     = r_done;
        n_time     = r_time;
        n_sum_tat  = r_sum_tat;
        n_sum_wt   = r_sum_wt;
        n_gv       = (r_state == S_GAP);
        n_gi       = r_idx;
        n_any      = r_any;
        n_gfound   = r_gfound;
        n_gmin     = r_gmin;
        n_bfound   = r_bfound;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_best_na  = r_best_na;
        n_best_b1  = r_best_b1;
        n_cand     = r_cand;
        n_c        = r_c;
        n_c_na     = r_c_na;
        n_c_b1     = r_c_b1;
        n_pl       = r_pl;
        n_pr       = r_pr;
        n_ov       = r_ov;
        n_out      = r_out;
        o_cmd_take = 1'b0;
        w_we       = 1'b0;

        // gap scan: any arrived pending item, earliest pending arrival
        if (r_gv && !r_done[r_gi[IW-1:0]]) begin
            if (TW'(w_rd.arr) <= r_time) begin
                n_any = 1'b1;
            end
            if (!r_gfound || (w_rd.arr < r_gmin)) begin
                n_gmin   = w_rd.arr;
                n_gfound = 1'b1;
            end
        end

        if (i_pop && r_ov) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    if (i_cmd.op == OP_LOAD) begin
                        if (r_count < CW'(MAX_PROCS)) begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count != '0) begin
                        n_done    = '0;
                        n_time    = '0;
                        n_sum_tat = '0;
                        n_sum_wt  = '0;
                        n_k       = '0;
                        n_idx     = '0;
                        n_any     = 1'b0;
                        n_gfound  = 1'b0;
                        n_state   = S_GAP;
                    end
                end
            end
            S_GAP: begin
                if (r_idx == w_last) begin
                    n_state = S_GAPEND;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            S_GAPEND: begin
                n_state = S_GAPFIX;
            end
            S_GAPFIX: begin
                if (!r_any && r_gfound) begin
                    n_time = TW'(r_gmin);
                end
                n_idx    = '0;
                n_bfound = 1'b0;
                n_state  = S_BRD;
            end
            S_BRD: begin
                n_state = S_BMUL;
            end
            S_BMUL: begin
                n_cand  = !r_done[r_idx[IW-1:0]] && (TW'(w_rd.arr) <= r_time);
                n_c     = w_rd;
                n_c_na  = w_na;
                n_c_b1  = w_b1;
                n_pl    = w_na * r_best_b1;
                n_pr    = r_best_na * w_b1;
                n_state = S_BCMP;
            end
            S_BCMP: begin
                if (w_win) begin
                    n_bfound   = 1'b1;
                    n_best     = r_c;
                    n_best_na  = r_c_na;
                    n_best_b1  = r_c_b1;
                    n_best_idx = r_idx;
                end
                if (r_idx == w_last) begin
                    n_state = S_RUN;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_BRD;
                end
            end
            S_RUN: begin
                if (w_out_free) begin
                    n_time                   = w_fin;
                    n_sum_tat                = w_sum_tat;
                    n_sum_wt                 = w_sum_wt;
                    n_done[r_best_idx[IW-1:0]] = 1'b1;
                    n_out.chosen_id          = r_best.id;
                    n_out.finish_time        = 21'(w_fin);
                    n_out.turnaround         = 21'(w_tat);
                    n_out.wait_time          = 21'(w_wt);
                    n_out.sum_turnaround     = 25'(w_sum_tat);
                    n_out.sum_wait           = 25'(w_sum_wt);
                    n_out.is_last            = (r_k == w_last);
                    n_ov                     = 1'b1;
                    if (r_k == w_last) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k      = r_k + CW'(1);
                        n_idx    = '0;
                        n_any    = 1'b0;
                        n_gfound = 1'b0;
                        n_state  = S_GAP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= '0;
            r_time  <= '0;
            r_gv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_time  <= n_time;
            r_gv    <= n_gv;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_sum_tat  <= n_sum_tat;
        r_sum_wt   <= n_sum_wt;
        r_gi       <= n_gi;
        r_any      <= n_any;
        r_gfound   <= n_gfound;
        r_gmin     <= n_gmin;
        r_bfound   <= n_bfound;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_best_na  <= n_best_na;
        r_best_b1  <= n_best_b1;
        r_cand     <= n_cand;
        r_c        <= n_c;
        r_c_na     <= n_c_na;
        r_c_b1     <= n_c_b1;
        r_pl       <= n_pl;
        r_pr       <= n_pr;
        r_out      <= n_out;
    end

endmodule

@@ rtl/core/hrrn_process_scheduler.sv @@
`timescale 1ns / 1ps

// Highest-response-ratio-next scheduler.
// Input queue: drive i_item and raise push while full is low. action 0 loads
// one process (id, arrival, burst) into a table of MAX_PROCS entries; loads
// into a full table are dropped. action 1 schedules the loaded batch.
// Result queue: while empty is low, o_item holds the oldest result; pop takes
// it. A start yields one result per loaded entry in schedule order; the last
// one has is_last set and carries the run totals. The table then empties.
// A two-entry input queue sits in front of the sequencer, so up to two items
// are taken while a run is busy. Each result of a run takes one pass over the
// table for the idle-gap check (one read a cycle, then an end and a fix step)
// and one ratio pass that reads, cross-multiplies and compares each entry in
// turn, plus the emit step. A start on an empty table gives no result.
// While the result is not popped the sequencer waits at its emit step.
// Reset (synchronous, active low) empties both queues and the table.
module hrrn_process_scheduler import hrrn_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_take;

    hrrn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    hrrn_back #(
        .MAX_PROCS (MAX_PROCS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_item      (o_item)
    );

endmodule

@@ rtl/core/hrrn_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrrn_checker import hrrn_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      push,
    input logic      full,
    input t_in_item  i_item,
    input logic      empty,
    input logic      pop,
    input t_out_item o_item
);

    // totals stay exact in the result fields only for small tables
    localparam logic EXACT = (MAX_PROCS <= 31);

    logic [24:0] r_prev_tat;
    logic [24:0] r_prev_wt;
    logic        w_push_seen;

    assign w_push_seen = push && !full && (i_item.action == OP_START);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_tat <= '0;
            r_prev_wt  <= '0;
        end else if (pop && !empty) begin
            if (o_item.is_last) begin
                r_prev_tat <= '0;
                r_prev_wt  <= '0;
            end else begin
                r_prev_tat <= o_item.sum_turnaround;
                r_prev_wt  <= o_item.sum_wait;
            end
        end
    end

    `ASSERT_RST(a_reset_clears, !i_rst_n |=> (empty && !full))
    `ASSERT_CLK(a_stall_holds, (!empty && !pop) |=> (!empty && $stable(o_item)))
    `ASSERT_CLK(a_sum_tat, (!empty && EXACT && (w_push_seen || !w_push_seen)) |-> (o_item.sum_turnaround == 25'(r_prev_tat + 25'(o_item.turnaround))))
    `ASSERT_CLK(a_sum_wt, (!empty && EXACT) |-> (o_item.sum_wait == 25'(r_prev_wt + 25'(o_item.wait_time))))

endmodule

bind hrrn_process_scheduler hrrn_checker #(.MAX_PROCS(MAX_PROCS)) u_checker (.*);
